@@ hdl/rc_frame_parser_crc8_channels_defines.svh @@
// ---------------------------------------------------------------------------
// rc frame parser assertion macros
// clocked assertion helpers for the rc frame parser, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef RC_FRAME_PARSER_CRC8_CHANNELS_DEFINES_SVH
`define RC_FRAME_PARSER_CRC8_CHANNELS_DEFINES_SVH
`ifndef SYNTH
// check on every clock edge outside reset
`define RFP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rc frame parser assertion failed");
// check on every clock edge, reset included
`define RFP_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("rc frame parser assertion failed");
`else
`define RFP_ASSERT(lbl, prop)
`define RFP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ hdl/rfp_pkg.sv @@
// ---------------------------------------------------------------------------
// rc frame parser package
// shared constants, stage type and crc helper for the rc frame parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfp_pkg;

   localparam int MAX_FRAME_LEN_DEF = 64;
   localparam int NUM_CH            = 7;
   localparam int NUM_CAP           = 10;
   localparam int RAW_W             = 11;
   localparam int US_W              = 12;

   localparam logic [7:0] SYNC_RESET = 8'd200;
   localparam logic [7:0] TYPE_RESET = 8'd22;
   localparam logic [7:0] CRC_POLY   = 8'hD5;

   // register indexes of the write port
   localparam logic CSR_SYNC_VALUE = 1'b0;
   localparam logic CSR_FRAME_TYPE = 1'b1;

   // us = US_BASE + floor((raw * 1024 + US_ROUND) / 1639)
   localparam int US_BASE     = 880;
   localparam int US_ROUND    = 884;
   localparam int NUM_W       = RAW_W + 10;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 22;
   localparam logic [RECIP_W-1:0] RECIP = 22'd2620481;

   localparam logic [NUM_CH-1:0][US_W-1:0] CH_RESET = {
      12'd1000, 12'd1000, 12'd1000, 12'd1500, 12'd1000, 12'd1500, 12'd1500
   };

   typedef struct packed {
      logic                          ok;
      logic                          failsafe;
      logic [NUM_CH-1:0][RAW_W-1:0]  raw;
   } stage_type;

   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hdl/rfp_parser.sv @@
// ---------------------------------------------------------------------------
// rc frame parser byte stage
// frame state machine, running crc and payload capture, one byte per cycle while take is high
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfp_parser #(
   parameter int MAX_FRAME_LEN = rfp_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic                drain,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          sync_value,
   input  logic [7:0]          channels_frame_type,
   output logic                s1_valid,
   output rfp_pkg::stage_type  s1
);

   localparam logic [7:0] LEN_MAX   = 8'(MAX_FRAME_LEN);
   localparam int         CAP_IDX_W = $clog2(rfp_pkg::NUM_CAP);

   typedef enum logic [2:0] {
      PH_SYNC    = 3'd0,
      PH_LEN     = 3'd1,
      PH_TYPE    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC     = 3'd4
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] kind_ff, kind_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [rfp_pkg::NUM_CAP-1:0][7:0] cap_ff, cap_in;
   logic fs_ff, fs_in;
   logic ok;
   logic s1_valid_ff, s1_valid_in;
   rfp_pkg::stage_type s1_ff, s1_in;
   logic [rfp_pkg::NUM_CAP*8-1:0] cap_flat;

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      kind_in  = kind_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      cap_in   = cap_ff;
      fs_in    = fs_ff;
      ok       = 1'b0;
      unique case (phase_ff)
         PH_LEN: begin
            if (rx_byte >= 8'd2 && rx_byte <= LEN_MAX) begin
               len_in   = rx_byte;
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_SYNC;
            end
         end
         PH_TYPE: begin
            kind_in  = rx_byte;
            count_in = 8'd0;
            crc_in   = rfp_pkg::crc_update(8'd0, rx_byte);
            phase_in = (len_ff <= 8'd2) ? PH_CRC : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (count_ff < 8'(rfp_pkg::NUM_CAP)) begin
               cap_in[count_ff[CAP_IDX_W-1:0]] = rx_byte;
            end
            crc_in   = rfp_pkg::crc_update(crc_ff, rx_byte);
            count_in = count_ff + 8'd1;
            if ({1'b0, count_in} + 9'd2 >= {1'b0, len_ff}) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            phase_in = PH_SYNC;
            if (crc_ff == rx_byte && kind_ff == channels_frame_type) begin
               ok    = 1'b1;
               fs_in = 1'b0;
            end
         end
         default: begin
            phase_in = (rx_byte == sync_value) ? PH_LEN : PH_SYNC;
         end
      endcase
   end

   // channels are packed lsb first across the captured bytes
   assign cap_flat = cap_ff;

   always_comb begin
      s1_in.ok       = ok;
      s1_in.failsafe = fs_in;
      for (int i = 0; i < rfp_pkg::NUM_CH; i++) begin
         s1_in.raw[i] = cap_flat[i*rfp_pkg::RAW_W +: rfp_pkg::RAW_W];
      end
   end

   always_comb begin
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (drain) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC;
         len_ff      <= 8'd0;
         kind_ff     <= 8'd0;
         count_ff    <= 8'd0;
         crc_ff      <= 8'd0;
         cap_ff      <= '0;
         fs_ff       <= 1'b1;
         s1_valid_ff <= 1'b0;
         s1_ff       <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            kind_ff  <= kind_in;
            count_ff <= count_in;
            crc_ff   <= crc_in;
            cap_ff   <= cap_in;
            fs_ff    <= fs_in;
            s1_ff    <= s1_in;
         end
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

@@ hdl/rfp_ch_conv.sv @@
// ---------------------------------------------------------------------------
// rc frame parser channel converter
// maps one 11-bit raw channel to a pulse width in microseconds
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfp_ch_conv (
   input  logic [rfp_pkg::RAW_W-1:0] raw,
   output logic [rfp_pkg::US_W-1:0]  us
);

   localparam int PROD_W = rfp_pkg::NUM_W + rfp_pkg::RECIP_W;

   logic [rfp_pkg::NUM_W-1:0] num;
   logic [PROD_W-1:0]         prod;
   logic [rfp_pkg::RAW_W-1:0] quot;

   // divide by 1639 through a reciprocal, exact over the whole numerator range
   assign num  = {raw, 10'd0} + rfp_pkg::NUM_W'(rfp_pkg::US_ROUND);
   assign prod = PROD_W'(num) * PROD_W'(rfp_pkg::RECIP);
   assign quot = prod[rfp_pkg::RECIP_SHIFT +: rfp_pkg::RAW_W];
   assign us   = rfp_pkg::US_W'(rfp_pkg::US_BASE) + {1'b0, quot};

endmodule

@@ hdl/rc_frame_parser_crc8_channels.sv @@
// ---------------------------------------------------------------------------
// rc frame parser with crc-8 and channel decode
// top level: write port, parser stage, channel conversion and result stage
// ---------------------------------------------------------------------------
// Usage:
//  req_ channel carries one received byte per item; every accepted byte
//  produces exactly one rsp_ item carrying frame_ok, failsafe and the seven
//  channel pulse widths as they stand after that byte.
//  csr_ port writes sync_value (index 0) and channels_frame_type (index 1)
//  in the cycle csr_we is high; write only while no item is in flight.
//  An accepted byte's result is registered after the parser stage and again
//  after conversion before it shows on rsp_.
//  Throughput: one byte per cycle while rsp_ready stays high; the seven parallel
//  reciprocal converters are combinational between the parser and result stages.
//  Reset: parser returns to sync search, failsafe is set, channels load
//  their idle pulse widths and both stages empty.
//  Stall: a result held by rsp_ready low keeps one more byte in the parser
//  stage; req_ready drops only when both stages are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rc_frame_parser_crc8_channels_defines.svh"

module rc_frame_parser_crc8_channels #(
   parameter int MAX_FRAME_LEN = rfp_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [7:0]                csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_frame_ok,
   output logic                      rsp_failsafe,
   output logic [rfp_pkg::US_W-1:0]  rsp_roll_us,
   output logic [rfp_pkg::US_W-1:0]  rsp_pitch_us,
   output logic [rfp_pkg::US_W-1:0]  rsp_throttle_us,
   output logic [rfp_pkg::US_W-1:0]  rsp_yaw_us,
   output logic [rfp_pkg::US_W-1:0]  rsp_arm_us,
   output logic [rfp_pkg::US_W-1:0]  rsp_mode_us,
   output logic [rfp_pkg::US_W-1:0]  rsp_return_us
);

   logic [7:0] sync_ff;
   logic [7:0] ftype_ff;
   logic take;
   logic drain;
   logic s1_valid;
   rfp_pkg::stage_type s1;
   logic [rfp_pkg::NUM_CH-1:0][rfp_pkg::US_W-1:0] conv_us;
   logic [rfp_pkg::NUM_CH-1:0][rfp_pkg::US_W-1:0] ch_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic ok_ff;
   logic fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff  <= rfp_pkg::SYNC_RESET;
         ftype_ff <= rfp_pkg::TYPE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rfp_pkg::CSR_SYNC_VALUE: sync_ff  <= csr_wdata;
            rfp_pkg::CSR_FRAME_TYPE: ftype_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign drain     = s1_valid && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid || drain;
   assign take      = req_valid && req_ready;

   rfp_parser #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN)
   ) u_parser (
      .clock               (clock),
      .reset               (reset),
      .take                (take),
      .drain               (drain),
      .rx_byte             (req_rx_byte),
      .sync_value          (sync_ff),
      .channels_frame_type (ftype_ff),
      .s1_valid            (s1_valid),
      .s1                  (s1)
   );

   for (genvar g = 0; g < rfp_pkg::NUM_CH; g++) begin : g_conv
      rfp_ch_conv u_conv (
         .raw (s1.raw[g]),
         .us  (conv_us[g])
      );
   end

   always_comb begin
      if (drain) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // channel registers hold the decoded state between good frames
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
         fs_ff        <= 1'b1;
         ch_ff        <= rfp_pkg::CH_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (drain) begin
            ok_ff <= s1.ok;
            fs_ff <= s1.failsafe;
            if (s1.ok) begin
               ch_ff <= conv_us;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_ok    = ok_ff;
   assign rsp_failsafe    = fs_ff;
   assign rsp_roll_us     = ch_ff[0];
   assign rsp_pitch_us    = ch_ff[1];
   assign rsp_throttle_us = ch_ff[2];
   assign rsp_yaw_us      = ch_ff[3];
   assign rsp_arm_us      = ch_ff[4];
   assign rsp_mode_us     = ch_ff[5];
   assign rsp_return_us   = ch_ff[6];

   `RFP_ASSERT(a_ok_clears_failsafe, rsp_valid && rsp_frame_ok |-> !rsp_failsafe)
   `RFP_ASSERT(a_failsafe_sticks_clear, !rsp_failsafe |=> !rsp_failsafe)
   `RFP_ASSERT(a_stall_only_when_full, !req_ready |-> (rsp_valid && !rsp_ready))
   `RFP_ASSERT(a_ok_only_after_drain, $rose(rsp_frame_ok) |-> $past(drain))

endmodule

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// rc frame parser testbench
// feeds serial bytes through the valid/ready request channel, predicts every
// response item with a cycle-free parser model kept beside the dut, and
// compares each response field by field. covers short directed frames, then
// random well-formed, corrupted, truncated and noise traffic under several
// register settings, random idling on both sides and one long receiver stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int MAX_LEN  = rfp_pkg::MAX_FRAME_LEN_DEF;
   localparam int LIMIT_NS = 5_000_000;

   localparam logic [rfp_pkg::NUM_CH-1:0][rfp_pkg::US_W-1:0] IDLE_US = {
      12'd1000, 12'd1000, 12'd1000, 12'd1500, 12'd1000, 12'd1500, 12'd1500
   };

   typedef enum logic [2:0] {
      SEEK_SYNC, TAKE_LENGTH, TAKE_KIND, TAKE_PAYLOAD, TAKE_CRC
   } parse_phase_type;

   typedef enum int { FILL_RANDOM, FILL_ONES, FILL_ZEROS } fill_mode_type;

   typedef struct packed {
      logic                                             ok;
      logic                                             fs;
      logic [rfp_pkg::NUM_CH-1:0][rfp_pkg::US_W-1:0]    us;
   } rc_result_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic                       csr_index;
   logic [7:0]                 csr_wdata;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_frame_ok;
   logic                       rsp_failsafe;
   logic [rfp_pkg::US_W-1:0]   rsp_roll_us;
   logic [rfp_pkg::US_W-1:0]   rsp_pitch_us;
   logic [rfp_pkg::US_W-1:0]   rsp_throttle_us;
   logic [rfp_pkg::US_W-1:0]   rsp_yaw_us;
   logic [rfp_pkg::US_W-1:0]   rsp_arm_us;
   logic [rfp_pkg::US_W-1:0]   rsp_mode_us;
   logic [rfp_pkg::US_W-1:0]   rsp_return_us;

   // parser model state
   logic [7:0]                                      cfg_sync;
   logic [7:0]                                      cfg_kind;
   parse_phase_type                                 ph;
   logic [7:0]                                      flen;
   logic [7:0]                                      fkind;
   logic [7:0]                                      pcount;
   logic [7:0]                                      crc_acc;
   logic [7:0]                                      cap [rfp_pkg::NUM_CAP];
   logic [rfp_pkg::NUM_CH-1:0][rfp_pkg::US_W-1:0]   chan;
   logic                                            fs;

   rc_result_type  expected_q [$];
   int             errors      = 0;
   int             items_sent  = 0;
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;
   int             hold_left   = 0;

   string ch_names [rfp_pkg::NUM_CH] = '{"roll_us", "pitch_us", "throttle_us", "yaw_us",
                                         "arm_us", "mode_us", "return_us"};

   rc_frame_parser_crc8_channels #(.MAX_FRAME_LEN(MAX_LEN)) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_ok    (rsp_frame_ok),
      .rsp_failsafe    (rsp_failsafe),
      .rsp_roll_us     (rsp_roll_us),
      .rsp_pitch_us    (rsp_pitch_us),
      .rsp_throttle_us (rsp_throttle_us),
      .rsp_yaw_us      (rsp_yaw_us),
      .rsp_arm_us      (rsp_arm_us),
      .rsp_mode_us     (rsp_mode_us),
      .rsp_return_us   (rsp_return_us)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] crc8_d5(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] c;
      c = acc ^ data;
      repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ rfp_pkg::CRC_POLY) : {c[6:0], 1'b0};
      return c;
   endfunction

   function automatic logic [rfp_pkg::US_W-1:0] raw_to_us(
      input logic [rfp_pkg::RAW_W-1:0] raw
   );
      int unsigned v;
      v = raw;
      return rfp_pkg::US_W'(880 + (v * 1024 + 884) / 1639);
   endfunction

   function automatic void parser_model_reset();
      cfg_sync = 8'd200;
      cfg_kind = 8'd22;
      ph       = SEEK_SYNC;
      flen     = '0;
      fkind    = '0;
      pcount   = '0;
      crc_acc  = '0;
      for (int i = 0; i < rfp_pkg::NUM_CAP; i++) cap[i] = '0;
      chan     = IDLE_US;
      fs       = 1'b1;
   endfunction

   function automatic void decode_channels();
      logic [rfp_pkg::NUM_CAP*8-1:0] bits;
      for (int i = 0; i < rfp_pkg::NUM_CAP; i++) bits[i*8 +: 8] = cap[i];
      for (int i = 0; i < rfp_pkg::NUM_CH; i++) begin
         chan[i] = raw_to_us(bits[i*rfp_pkg::RAW_W +: rfp_pkg::RAW_W]);
      end
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      rc_result_type r;
      r.ok = 1'b0;
      case (ph)
         TAKE_LENGTH: begin
            if (b >= 2 && b <= MAX_LEN) begin
               flen = b;
               ph   = TAKE_KIND;
            end else begin
               ph = SEEK_SYNC;
            end
         end
         TAKE_KIND: begin
            fkind   = b;
            pcount  = '0;
            crc_acc = crc8_d5(8'h00, b);
            ph      = (flen <= 2) ? TAKE_CRC : TAKE_PAYLOAD;
         end
         TAKE_PAYLOAD: begin
            if (pcount < rfp_pkg::NUM_CAP) cap[pcount] = b;
            crc_acc = crc8_d5(crc_acc, b);
            pcount  = pcount + 8'd1;
            if (int'(pcount) + 2 >= int'(flen)) ph = TAKE_CRC;
         end
         TAKE_CRC: begin
            ph = SEEK_SYNC;
            if (crc_acc == b && fkind == cfg_kind) begin
               decode_channels();
               fs   = 1'b0;
               r.ok = 1'b1;
            end
         end
         default: begin
            ph = (b == cfg_sync) ? TAKE_LENGTH : SEEK_SYNC;
         end
      endcase
      r.fs = fs;
      r.us = chan;
      expected_q.push_back(r);
   endfunction

   task automatic check_result();
      rc_result_type got;
      rc_result_type want;
      got.ok    = rsp_frame_ok;
      got.fs    = rsp_failsafe;
      got.us[0] = rsp_roll_us;
      got.us[1] = rsp_pitch_us;
      got.us[2] = rsp_throttle_us;
      got.us[3] = rsp_yaw_us;
      got.us[4] = rsp_arm_us;
      got.us[5] = rsp_mode_us;
      got.us[6] = rsp_return_us;
      if (expected_q.size() == 0) begin
         $error("response item with no byte outstanding");
         errors++;
      end else begin
         want = expected_q.pop_front();
         if (got.ok !== want.ok) begin
            $error("frame_ok expected %0d actual %0d", want.ok, got.ok);
            errors++;
         end
         if (got.fs !== want.fs) begin
            $error("failsafe expected %0d actual %0d", want.fs, got.fs);
            errors++;
         end
         for (int i = 0; i < rfp_pkg::NUM_CH; i++) begin
            if (got.us[i] !== want.us[i]) begin
               $error("%s expected %0d actual %0d", ch_names[i], want.us[i], got.us[i]);
               errors++;
            end
         end
      end
   endtask

   // model and scoreboard, sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         parser_model_reset();
         expected_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == rfp_pkg::CSR_SYNC_VALUE) cfg_sync = csr_wdata;
            else cfg_kind = csr_wdata;
         end
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) predict_byte(req_rx_byte);
      end
   end

   // receiver
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_registers(input logic [7:0] sync_byte, input logic [7:0] kind);
      write_reg(rfp_pkg::CSR_SYNC_VALUE, sync_byte);
      write_reg(rfp_pkg::CSR_FRAME_TYPE, kind);
   endtask

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_frame(input logic [7:0] kind, input logic [7:0] len,
                             input bit bad_crc, input fill_mode_type fill);
      logic [7:0] crc;
      logic [7:0] b;
      send_byte(cfg_sync);
      send_byte(len);
      send_byte(kind);
      crc = crc8_d5(8'h00, kind);
      for (int i = 0; i < int'(len) - 2; i++) begin
         case (fill)
            FILL_ONES:  b = 8'hFF;
            FILL_ZEROS: b = 8'h00;
            default:    b = 8'($urandom_range(0, 255));
         endcase
         crc = crc8_d5(crc, b);
         send_byte(b);
      end
      send_byte(bad_crc ? crc ^ 8'(1 << $urandom_range(0, 7)) : crc);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_length_two();
      send_frame(cfg_kind, 8'd2, 1'b0, FILL_RANDOM);
   endtask

   task automatic test_bad_length();
      send_byte(cfg_sync);
      send_byte(8'd1);
      // the sync value used as a length is out of range and not taken as sync
      send_byte(cfg_sync);
      send_byte(cfg_sync);
      send_byte(cfg_sync);
      send_byte(8'(MAX_LEN + 1));
   endtask

   task automatic test_bad_crc();
      send_frame(cfg_kind, 8'd2, 1'b1, FILL_RANDOM);
   endtask

   task automatic test_other_type();
      send_frame(cfg_kind ^ 8'h01, 8'd2, 1'b0, FILL_RANDOM);
   endtask

   task automatic test_short_frame();
      send_frame(cfg_kind, 8'd4, 1'b0, FILL_ONES);
   endtask

   task automatic test_random_traffic(input int n);
      int            target;
      int            pick;
      int            len;
      int            cut;
      logic [7:0]    kind;
      fill_mode_type fill;
      target = items_sent + n;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            len = $urandom_range(0, 99);
            if (len < 10) len = 2;
            else if (len < 80) len = $urandom_range(3, 13);
            else if (len < 95) len = $urandom_range(14, 26);
            else if (len < 98) len = $urandom_range(27, MAX_LEN);
            else len = MAX_LEN;
            kind = ($urandom_range(0, 99) < 85) ? cfg_kind : 8'($urandom_range(0, 255));
            fill = FILL_RANDOM;
            if ($urandom_range(0, 99) < 10) fill = $urandom_range(0, 1) ? FILL_ONES : FILL_ZEROS;
            send_frame(kind, 8'(len), pick >= 70, fill);
         end else if (pick < 87) begin
            send_byte(cfg_sync);
            if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 1)));
            else send_byte(8'($urandom_range(MAX_LEN + 1, 255)));
         end else if (pick < 93) begin
            len = $urandom_range(3, 26);
            cut = $urandom_range(0, len - 3);
            send_byte(cfg_sync);
            send_byte(8'(len));
            send_byte(cfg_kind);
            repeat (cut) send_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_left = 300;
      send_frame(cfg_kind, 8'd24, 1'b0, FILL_RANDOM);
      send_frame(cfg_kind, 8'd24, 1'b0, FILL_RANDOM);
   endtask

   initial begin
      csr_we      = 1'b0;
      csr_index   = rfp_pkg::CSR_SYNC_VALUE;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      reset       = 1'b1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      set_registers(8'd200, 8'd22);
      test_length_two();
      test_bad_length();
      test_bad_crc();
      test_other_type();
      test_short_frame();
      wait_for_results();

      tx_idle_pct = 28;
      rx_idle_pct = 45;
      test_random_traffic(350);
      wait_for_results();

      set_registers(8'd0, 8'd255);
      tx_idle_pct = 45;
      rx_idle_pct = 28;
      test_random_traffic(350);
      wait_for_results();

      set_registers(8'd255, 8'd0);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_backpressure();
      test_random_traffic(150);
      wait_for_results();

      set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      test_random_traffic(200);
      wait_for_results();

      if (errors == 0 && expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
